// File: src/met_pkg.sv
// Shared types and constants for the escape-time iteration block.
`default_nettype none

package met_pkg;

  localparam int unsigned CRD_W     = 28;
  localparam int unsigned Z_W       = 40;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned BAIL_W    = 14;
  localparam int unsigned MAG_OUT_W = 40;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT_SQ = 2'd1;

  localparam logic [CNT_W-1:0]  MAX_ITER_RST   = 16'd400;
  localparam logic [BAIL_W-1:0] BAILOUT_SQ_RST = 14'd64;

  typedef struct packed {
    logic signed [CRD_W-1:0] c_re;
    logic signed [CRD_W-1:0] c_im;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]     iteration_count;
    logic                 escaped;
    logic [MAG_OUT_W-1:0] final_mag_sq;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic abs;
    logic mul0;
    logic mul1;
    logic mul2;
    logic ev1;
    logic ev2;
    logic inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic esc;
    logic last;
    logic max_zero;
  } status_t;

endpackage

`default_nettype wire

// File: src/mandelbrot_escape_time_top.sv
// Top level of the escape-time iteration block with its configuration registers.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  in_data_i  (c_re, c_im)
// out       output     out_valid_o/out_stall_i out_data_o (count, escaped, magnitude)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each iteration steps through the z update, the magnitudes, three multiply steps
// on three 40 by 20 bit multipliers, two evaluation steps and the bailout check.
// Reset loads max_iter with 400 and bailout_sq with 64; no clearing pass follows.
// The result sits in an output register, so the next item is taken while it waits;
// the block holds only when a second result is ready before the first is taken.
`default_nettype none

module mandelbrot_escape_time_top #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire met_pkg::in_item_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output met_pkg::out_item_t                      out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [met_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [met_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  logic [met_pkg::CNT_W-1:0]  max_iter_q;
  logic [met_pkg::BAIL_W-1:0] bailout_sq_q;
  met_pkg::cmd_t              cmd;
  met_pkg::status_t           status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q   <= met_pkg::MAX_ITER_RST;
      bailout_sq_q <= met_pkg::BAILOUT_SQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        met_pkg::CFG_MAX_ITER: begin
          max_iter_q <= cfg_data_i[met_pkg::CNT_W-1:0];
        end
        met_pkg::CFG_BAILOUT_SQ: begin
          bailout_sq_q <= cfg_data_i[met_pkg::BAIL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  met_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  met_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (in_data_i),
    .max_iter_i   (max_iter_q),
    .bailout_sq_i (bailout_sq_q),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// File: src/met_dpath.sv
// Datapath: working z, shared multipliers, magnitude test and result register.
`default_nettype none

module met_dpath #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                             clk_i,
  input  wire met_pkg::cmd_t                    cmd_i,
  output met_pkg::status_t                      status_o,
  input  wire met_pkg::in_item_t                in_data_i,
  input  wire logic [met_pkg::CNT_W-1:0]        max_iter_i,
  input  wire logic [met_pkg::BAIL_W-1:0]       bailout_sq_i,
  output met_pkg::out_item_t                    out_data_o
);

  localparam int unsigned HALF_W = met_pkg::Z_W / 2;
  localparam int unsigned PP_W   = met_pkg::Z_W + HALF_W;
  localparam int unsigned ACC_W  = 2 * met_pkg::Z_W;
  localparam int unsigned PROD_W = 62;
  localparam int unsigned MAG_W  = PROD_W + 1;
  localparam int unsigned SUM_W  = 64;

  localparam logic [ACC_W-1:0] PROD_CAP = ACC_W'(1) << (PROD_W - 1);
  localparam logic signed [SUM_W-1:0] Z_MAX = SUM_W'(64'sd549755813887);
  localparam logic signed [SUM_W-1:0] Z_MIN = -SUM_W'(64'sd549755813888);

  function automatic logic signed [met_pkg::Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
    logic signed [met_pkg::Z_W-1:0] r;
    if (v > Z_MAX) begin
      r = Z_MAX[met_pkg::Z_W-1:0];
    end else if (v < Z_MIN) begin
      r = Z_MIN[met_pkg::Z_W-1:0];
    end else begin
      r = v[met_pkg::Z_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] cap_prod(input logic [ACC_W-1:0] v);
    logic [PROD_W-1:0] r;
    if (v > PROD_CAP) begin
      r = PROD_CAP[PROD_W-1:0];
    end else begin
      r = v[PROD_W-1:0];
    end
    return r;
  endfunction

  logic signed [met_pkg::CRD_W-1:0] c_re_q, c_im_q;
  logic signed [met_pkg::Z_W-1:0]   z_re_q, z_im_q;
  logic [met_pkg::Z_W-1:0]          mre_q, mim_q;
  logic                             xy_neg_q;
  logic [2:0][PP_W-1:0]             p_q;
  logic [2:0][ACC_W-1:0]            acc_q;
  logic [PROD_W-1:0]                re2_q, im2_q, xyp_q;
  logic signed [SUM_W-1:0]          xy_q;
  logic [MAG_W-1:0]                 mag_q;
  logic                             esc_q;
  logic [met_pkg::CNT_W-1:0]        cnt_q;
  met_pkg::out_item_t               out_q;

  logic [2:0][met_pkg::Z_W-1:0] op_a, op_b;
  logic signed [SUM_W-1:0]      sum_re, sum_im;
  logic [MAG_W-1:0]             mag_d;
  logic [MAG_W-1:0]             limit;
  logic signed [SUM_W-1:0]      xy_pos;

  assign op_a = {mre_q, mim_q, mre_q};
  assign op_b = {mim_q, mim_q, mre_q};

  assign sum_re = $signed({2'b00, re2_q}) - $signed({2'b00, im2_q})
                + $signed({{(SUM_W-met_pkg::CRD_W){c_re_q[met_pkg::CRD_W-1]}}, c_re_q});
  assign sum_im = (xy_q <<< 1)
                + $signed({{(SUM_W-met_pkg::CRD_W){c_im_q[met_pkg::CRD_W-1]}}, c_im_q});

  assign mag_d  = {1'b0, re2_q} + {1'b0, im2_q};
  assign limit  = MAG_W'(bailout_sq_i) << FRAC_BITS;
  assign xy_pos = $signed({{(SUM_W-PROD_W){1'b0}}, xyp_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_re_q <= in_data_i.c_re;
      c_im_q <= in_data_i.c_im;
      re2_q  <= '0;
      im2_q  <= '0;
      xy_q   <= '0;
      mag_q  <= '0;
      esc_q  <= 1'b0;
      cnt_q  <= '0;
    end
    if (cmd_i.upd) begin
      z_re_q <= sat_z(sum_re);
      z_im_q <= sat_z(sum_im);
    end
    if (cmd_i.abs) begin
      mre_q    <= z_re_q[met_pkg::Z_W-1] ? met_pkg::Z_W'(-z_re_q) : z_re_q;
      mim_q    <= z_im_q[met_pkg::Z_W-1] ? met_pkg::Z_W'(-z_im_q) : z_im_q;
      xy_neg_q <= z_re_q[met_pkg::Z_W-1] ^ z_im_q[met_pkg::Z_W-1];
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.mul0) begin
        p_q[k] <= PP_W'(op_a[k]) * PP_W'(op_b[k][HALF_W-1:0]);
      end
      if (cmd_i.mul1) begin
        acc_q[k] <= ACC_W'(p_q[k]);
        p_q[k]   <= PP_W'(op_a[k]) * PP_W'(op_b[k][met_pkg::Z_W-1:HALF_W]);
      end
      if (cmd_i.mul2) begin
        acc_q[k] <= acc_q[k] + (ACC_W'(p_q[k]) << HALF_W);
      end
    end
    if (cmd_i.ev1) begin
      re2_q <= cap_prod(acc_q[0] >> FRAC_BITS);
      im2_q <= cap_prod(acc_q[1] >> FRAC_BITS);
      xyp_q <= cap_prod(acc_q[2] >> FRAC_BITS);
    end
    if (cmd_i.ev2) begin
      mag_q <= mag_d;
      esc_q <= (mag_d > limit);
      xy_q  <= xy_neg_q ? -xy_pos : xy_pos;
    end
    if (cmd_i.inc) begin
      cnt_q <= cnt_q + met_pkg::CNT_W'(1);
    end
    if (cmd_i.emit) begin
      out_q.iteration_count <= cnt_q;
      out_q.escaped         <= esc_q;
      out_q.final_mag_sq    <= (|mag_q[MAG_W-1:met_pkg::MAG_OUT_W]) ? '1
                                 : mag_q[met_pkg::MAG_OUT_W-1:0];
    end
  end

  assign status_o.esc      = esc_q;
  assign status_o.last     = (({1'b0, cnt_q} + (met_pkg::CNT_W+1)'(1)) == {1'b0, max_iter_i});
  assign status_o.max_zero = (max_iter_i == '0);
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

// File: src/met_ctrl.sv
// Controller: sequences the steps of each iteration and owns both handshakes.
`default_nettype none

module met_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output met_pkg::cmd_t         cmd_o,
  input  wire met_pkg::status_t status_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_ABS  = 4'd2;
  localparam logic [3:0] S_MUL0 = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_EV1  = 4'd6;
  localparam logic [3:0] S_EV2  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.max_zero ? S_DONE : S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_ABS;
      end
      S_ABS: begin
        cmd_o.abs = 1'b1;
        state_d   = S_MUL0;
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_EV1;
      end
      S_EV1: begin
        cmd_o.ev1 = 1'b1;
        state_d   = S_EV2;
      end
      S_EV2: begin
        cmd_o.ev2 = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (status_i.esc) begin
          state_d = S_DONE;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = status_i.last ? S_DONE : S_UPD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the escape-time iteration block and its configuration port.
module testbench;
  import met_pkg::*;

  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned IDLE_SETTLE  = 2;
  localparam int unsigned END_SETTLE   = 64;
  localparam int unsigned NUM_PHASES   = 13;
  localparam int unsigned NUM_DIRECTED = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [CRD_W-1:0] C_MAX          = 28'sh7FFFFFF;
  localparam logic signed [CRD_W-1:0] C_MIN          = 28'sh8000000;
  localparam logic signed [CRD_W-1:0] C_ZERO         = 28'sd0;
  localparam logic signed [CRD_W-1:0] C_LSB          = 28'sd1;
  localparam logic signed [CRD_W-1:0] C_NEG_LSB      = -28'sd1;
  localparam logic signed [CRD_W-1:0] C_QUARTER      = 28'sd4194304;
  localparam logic signed [CRD_W-1:0] C_HALF         = 28'sd8388608;
  localparam logic signed [CRD_W-1:0] C_ONE          = 28'sd16777216;
  localparam logic signed [CRD_W-1:0] C_NEG_ONE      = -28'sd16777216;
  localparam logic signed [CRD_W-1:0] C_ONE_HALF     = 28'sd25165824;
  localparam logic signed [CRD_W-1:0] C_NEG_ONE_HALF = -28'sd25165824;
  localparam logic signed [CRD_W-1:0] C_TWO          = 28'sd33554432;
  localparam logic signed [CRD_W-1:0] C_NEG_TWO      = -28'sd33554432;

  localparam logic [MAG_OUT_W-1:0] MAG_FOUR = 40'd67108864;

  localparam longint          Z_TOP       = 64'sd549755813887;
  localparam longint          Z_BOTTOM    = -64'sd549755813888;
  localparam longint unsigned PRODUCT_CAP = 64'd1 << 61;
  localparam longint unsigned MAG_CAP     = 64'hFF_FFFF_FFFF;

  localparam out_item_t NO_RESULT = '0;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    in_item_t             pt;
    logic                 known;
    out_item_t            res;
  } plan_row_t;

  plan_row_t plan [NUM_DIRECTED] = '{
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_ZERO, C_ZERO}, 1'b1, '{16'd400, 1'b0, 40'd0}},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MAX, C_MAX}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MIN, C_MIN}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MAX, C_MIN}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MIN, C_MAX}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_NEG_TWO, C_ZERO}, 1'b1, '{16'd400, 1'b0, MAG_FOUR}},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_QUARTER, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_NEG_ONE, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_ZERO, C_ONE}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_TWO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_NEG_LSB, C_LSB}, 1'b0, NO_RESULT},
    '{1'b1, CFG_MAX_ITER, 16'd0, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MAX, C_MAX}, 1'b1, '{16'd0, 1'b0, 40'd0}},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_ZERO, C_ZERO}, 1'b1, '{16'd0, 1'b0, 40'd0}},
    '{1'b1, CFG_MAX_ITER, 16'd16, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_BAILOUT_SQ, 16'd0, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_ZERO, C_ZERO}, 1'b1, '{16'd16, 1'b0, 40'd0}},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_LSB, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_HALF, C_HALF}, 1'b0, NO_RESULT},
    '{1'b1, CFG_MAX_ITER, 16'hFFFF, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_BAILOUT_SQ, 16'hFFFF, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_TWO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MAX, C_MIN}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_MIN, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_MAX_ITER, 16'd1, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_BAILOUT_SQ, 16'd4, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_SPARE_LO, 16'd0, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b1, CFG_SPARE_HI, 16'hFFFF, '{C_ZERO, C_ZERO}, 1'b0, NO_RESULT},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_TWO, C_ZERO}, 1'b1, '{16'd1, 1'b0, MAG_FOUR}},
    '{1'b0, CFG_MAX_ITER, 16'd0, '{C_NEG_ONE_HALF, C_ONE_HALF}, 1'b0, NO_RESULT}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_MAX_ITER;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;

  logic [CNT_W-1:0]  max_iter_q  = MAX_ITER_RST;
  logic [BAIL_W-1:0] bailout_q   = BAILOUT_SQ_RST;
  out_item_t         awaited_results [$];
  logic              calm        = 1'b0;
  int unsigned       next_gap    = 0;
  int unsigned       stall_left  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       mismatches  = 0;
  int unsigned       results_checked = 0;
  int unsigned       escapes_seen    = 0;
  int unsigned       saturated_seen  = 0;
  int unsigned       reg_writes      = 0;

  always #5 clk_i = ~clk_i;

  mandelbrot_escape_time_top #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b);
    logic [127:0] full;
    full = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
    if (full > {64'd0, PRODUCT_CAP}) return PRODUCT_CAP;
    return full[63:0];
  endfunction

  function automatic longint clamp_z(longint v);
    if (v > Z_TOP) return Z_TOP;
    if (v < Z_BOTTOM) return Z_BOTTOM;
    return v;
  endfunction

  function automatic out_item_t escape_time(in_item_t pt);
    longint          cr, ci, zr, zi, xy, p;
    longint unsigned re2, im2, mag, limit;
    int unsigned     cnt;
    logic            esc;
    out_item_t       res;
    cr    = longint'(pt.c_re);
    ci    = longint'(pt.c_im);
    zr    = 0;
    zi    = 0;
    re2   = 0;
    im2   = 0;
    mag   = 0;
    cnt   = 0;
    esc   = 1'b0;
    limit = longint'(bailout_q) << FRAC_BITS;
    while (!esc && cnt < max_iter_q) begin
      p  = longint'(scaled_product(magnitude(zr), magnitude(zi)));
      xy = ((zr < 0) != (zi < 0)) ? -p : p;
      zi = clamp_z(2 * xy + ci);
      zr = clamp_z(longint'(re2) - longint'(im2) + cr);
      re2 = scaled_product(magnitude(zr), magnitude(zr));
      im2 = scaled_product(magnitude(zi), magnitude(zi));
      mag = re2 + im2;
      if (mag > limit) begin
        esc = 1'b1;
      end else begin
        cnt++;
      end
    end
    res.iteration_count = cnt[CNT_W-1:0];
    res.escaped         = esc;
    res.final_mag_sq    = (mag > MAG_CAP) ? MAG_CAP[MAG_OUT_W-1:0] : mag[MAG_OUT_W-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_pause();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
  endfunction

  function automatic in_item_t draw_point();
    in_item_t    pt;
    int          re_v, im_v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      re_v = int'($urandom_range(0, 50331648)) - 37748736;
      im_v = int'($urandom_range(0, 50331648)) - 25165824;
    end else if (pick < 80) begin
      re_v = int'($urandom_range(0, 32'd1 << $urandom_range(0, 27)));
      im_v = int'($urandom_range(0, 32'd1 << $urandom_range(0, 27)));
      if ($urandom_range(0, 1) == 1) re_v = -re_v;
      if ($urandom_range(0, 1) == 1) im_v = -im_v;
    end else begin
      re_v = int'($urandom());
      im_v = int'($urandom());
    end
    pt.c_re = re_v[CRD_W-1:0];
    pt.c_im = im_v[CRD_W-1:0];
    return pt;
  endfunction

  task automatic send_point(input in_item_t pt, input logic known, input out_item_t res);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(known ? res : escape_time(pt));
    next_gap = calm ? 0 : (($urandom_range(0, 1) == 1) ? 0 : pick_pause());
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_ITER: max_iter_q = data;
      CFG_BAILOUT_SQ: bailout_q = data[BAIL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with no point waiting: count %0d escaped %0b magnitude %0d",
               out_data_o.iteration_count, out_data_o.escaped, out_data_o.final_mag_sq);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_data_o.escaped) escapes_seen++;
        if (out_data_o.final_mag_sq == MAG_CAP[MAG_OUT_W-1:0]) saturated_seen++;
        if (out_data_o.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d",
                 want.iteration_count, out_data_o.iteration_count);
          mismatches++;
        end
        if (out_data_o.escaped !== want.escaped) begin
          $error("escaped: expected %0b, got %0b", want.escaped, out_data_o.escaped);
          mismatches++;
        end
        if (out_data_o.final_mag_sq !== want.final_mag_sq) begin
          $error("final_mag_sq: expected %0d, got %0d",
                 want.final_mag_sq, out_data_o.final_mag_sq);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = pick_pause();
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned       n_items;
    logic [CNT_W-1:0]  mi;
    logic [BAIL_W-1:0] bo;
    logic [1:0]        spare_bits;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_point(plan[i].pt, plan[i].known, plan[i].res);
      end
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          mi = MAX_ITER_RST;
          bo = BAILOUT_SQ_RST;
        end
        1: begin
          mi = 16'd1;
          bo = 14'd4;
        end
        2: begin
          mi = 16'd0;
          bo = 14'($urandom_range(0, 16383));
        end
        3: begin
          mi = 16'd64;
          bo = 14'd16383;
        end
        4: begin
          mi = 16'd20;
          bo = 14'd0;
        end
        default: begin
          mi = 16'($urandom_range(1, 48));
          bo = 14'(($urandom_range(0, 99) < 30) ? $urandom_range(0, 16383)
                                                : $urandom_range(4, 100));
        end
      endcase
      n_items    = (p == 0) ? 40 : ((p == 2) ? 10 : 50);
      spare_bits = 2'($urandom());
      wait_idle();
      calm = (p % 5 == 4);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_MAX_ITER, mi);
        wait_idle();
        write_reg(CFG_BAILOUT_SQ, {spare_bits, bo});
      end else begin
        write_reg(CFG_BAILOUT_SQ, {spare_bits, bo});
        wait_idle();
        write_reg(CFG_MAX_ITER, mi);
      end
      for (int k = 0; k < n_items; k++) begin
        // Let the block run dry now and then so the next point finds it empty.
        if (k == n_items / 2 && p % 3 == 1) wait_idle();
        send_point(draw_point(), 1'b0, NO_RESULT);
      end
    end
    wait_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("summary: %0d points checked over %0d register writes, %0d escaped, %0d saturated",
             results_checked, reg_writes, escapes_seen, saturated_seen);
    $display("summary: field extremes and boundary points first, then random points around the set");
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
